// ===== rtl/srb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg: shared types and constants of the slot ring buffer
// Controller states, result status codes, op codes, register indexes and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int CFG_W  = 5;
    localparam int DATA_W = 8;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DATA_W-1:0] PAD_BYTE = 8'h00;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 5'd16;
    localparam logic [CFG_W-1:0] SLOT_BYTES_RST = 5'd16;

    localparam logic OP_FILL = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic REG_SLOT_BYTES = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMMIT,
        ST_READ
    } t_srb_state;

    typedef enum logic [1:0] {
        CODE_OK         = 2'd0,
        CODE_BAD_LENGTH = 2'd1,
        CODE_FULL       = 2'd2,
        CODE_EMPTY      = 2'd3
    } t_srb_code;

    typedef struct packed {
        logic      stage_wr;
        logic      fill_done;
        logic      commit_go;
        logic      mem_clr;
        logic      commit_wr;
        logic      rd_empty;
        logic      rd_go;
        logic      rd_issue;
        logic      rd_last;
        t_srb_code code;
    } t_srb_cmd;

    typedef struct packed {
        logic             out_free;
        logic             ring_empty;
        logic             ring_full;
        logic             len_bad;
        logic [CFG_W-1:0] nbytes;
    } t_srb_stat;

endpackage

// ===== rtl/srb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_regs: configuration registers
// APB-style register file holding slot_count and slot_bytes.
// ----------------------------------------------------------------------------
module srb_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srb_pkg::APB_AW-1:0] paddr,
    input  logic [srb_pkg::APB_DW-1:0] pwdata,
    output logic [srb_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [srb_pkg::CFG_W-1:0]  o_slot_count,
    output logic [srb_pkg::CFG_W-1:0]  o_slot_bytes
);

    logic [srb_pkg::CFG_W-1:0] r_slot_count;
    logic [srb_pkg::CFG_W-1:0] r_slot_bytes;
    logic                      w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= srb_pkg::SLOT_COUNT_RST;
            r_slot_bytes <= srb_pkg::SLOT_BYTES_RST;
        end else if (w_wr) begin
            case (paddr[2])
                srb_pkg::REG_SLOT_COUNT: begin
                    r_slot_count <= pwdata[srb_pkg::CFG_W-1:0];
                end
                srb_pkg::REG_SLOT_BYTES: begin
                    r_slot_bytes <= pwdata[srb_pkg::CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            srb_pkg::REG_SLOT_COUNT: begin
                prdata = srb_pkg::APB_DW'(r_slot_count);
            end
            srb_pkg::REG_SLOT_BYTES: begin
                prdata = srb_pkg::APB_DW'(r_slot_bytes);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_slot_count = r_slot_count;
    assign o_slot_bytes = r_slot_bytes;

endmodule

// ===== rtl/srb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ctrl: slot ring buffer controller
// State machine sequencing the clearing pass, request acceptance, slot commit
// and slot read-out, plus the byte/address counter.
// ----------------------------------------------------------------------------
module srb_ctrl #(
    parameter int  MAX_SLOTS      = 16,
    parameter int  MAX_SLOT_BYTES = 16,
    localparam int DEPTH          = MAX_SLOTS * MAX_SLOT_BYTES,
    localparam int AW             = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_op,
    input  logic                i_in_last,
    input  srb_pkg::t_srb_stat  i_stat,
    output logic                o_in_stall,
    output srb_pkg::t_srb_cmd   o_cmd,
    output logic [AW-1:0]       o_idx
);

    localparam int KW = (AW > srb_pkg::CFG_W) ? AW : srb_pkg::CFG_W;

    srb_pkg::t_srb_state r_state;
    srb_pkg::t_srb_state n_state;
    logic [AW-1:0]       r_cnt;
    logic [AW-1:0]       n_cnt;
    logic                w_byte_last;
    logic                w_clr_last;

    assign w_byte_last = (KW'(r_cnt) == (KW'(i_stat.nbytes) - KW'(1)));
    assign w_clr_last  = (r_cnt == AW'(DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srb_pkg::ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd        = '0;
        o_cmd.code   = srb_pkg::CODE_OK;
        o_in_stall   = 1'b1;
        case (r_state)
            srb_pkg::ST_CLEAR: begin
                o_cmd.mem_clr = 1'b1;
                if (w_clr_last) begin
                    n_state = srb_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            srb_pkg::ST_IDLE: begin
                o_in_stall = !i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    n_cnt = '0;
                    if (i_op == srb_pkg::OP_FILL) begin
                        o_cmd.stage_wr = 1'b1;
                        if (i_in_last) begin
                            o_cmd.fill_done = 1'b1;
                            if (i_stat.len_bad) begin
                                o_cmd.code = srb_pkg::CODE_BAD_LENGTH;
                            end else if (i_stat.ring_full) begin
                                o_cmd.code = srb_pkg::CODE_FULL;
                            end else begin
                                o_cmd.commit_go = 1'b1;
                                n_state         = srb_pkg::ST_COMMIT;
                            end
                        end
                    end else if (i_stat.ring_empty) begin
                        o_cmd.rd_empty = 1'b1;
                        o_cmd.code     = srb_pkg::CODE_EMPTY;
                    end else begin
                        o_cmd.rd_go = 1'b1;
                        n_state     = srb_pkg::ST_READ;
                    end
                end
            end
            srb_pkg::ST_COMMIT: begin
                o_cmd.commit_wr = 1'b1;
                if (w_byte_last) begin
                    n_state = srb_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            srb_pkg::ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    o_cmd.rd_last  = w_byte_last;
                    if (w_byte_last) begin
                        n_state = srb_pkg::ST_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + AW'(1);
                    end
                end
            end
            default: begin
                n_state = srb_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    assign o_idx = r_cnt;

endmodule

// ===== rtl/srb_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_dpath: slot ring buffer datapath
// Slot memory, staging slot, ring pointers, fill level and result register.
// ----------------------------------------------------------------------------
module srb_dpath #(
    parameter int  MAX_SLOTS      = 16,
    parameter int  MAX_SLOT_BYTES = 16,
    localparam int DEPTH          = MAX_SLOTS * MAX_SLOT_BYTES,
    localparam int AW             = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srb_pkg::t_srb_cmd           i_cmd,
    input  logic [AW-1:0]               i_idx,
    input  logic [srb_pkg::DATA_W-1:0]  i_data_in,
    input  logic                        i_out_stall,
    input  logic [srb_pkg::CFG_W-1:0]   i_slot_count,
    input  logic [srb_pkg::CFG_W-1:0]   i_slot_bytes,
    output srb_pkg::t_srb_stat          o_stat,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic [srb_pkg::DATA_W-1:0]  o_data_out,
    output logic                        o_out_last,
    output logic [srb_pkg::CFG_W-1:0]   o_level
);

    localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int BW  = (MAX_SLOT_BYTES > 1) ? $clog2(MAX_SLOT_BYTES) : 1;
    localparam int LW  = $clog2(MAX_SLOT_BYTES + 2);
    localparam int PW  = (SW > srb_pkg::CFG_W) ? SW : srb_pkg::CFG_W;
    localparam int LCW = (LW > srb_pkg::CFG_W) ? LW : srb_pkg::CFG_W;

    // wrap to slot 0 at or past the last slot in use
    function automatic logic [SW-1:0] f_advance(input logic [SW-1:0] p,
                                                input logic [srb_pkg::CFG_W-1:0] n);
        logic [SW-1:0] res;
        if (PW'(p) >= (PW'(n) - PW'(1))) begin
            res = '0;
        end else begin
            res = p + SW'(1);
        end
        return res;
    endfunction

    logic [srb_pkg::DATA_W-1:0] mem [DEPTH];
    logic [srb_pkg::DATA_W-1:0] r_rdata;
    logic [srb_pkg::DATA_W-1:0] r_stg [MAX_SLOT_BYTES];

    logic [SW-1:0]              r_head, n_head;
    logic [SW-1:0]              r_tail, n_tail;
    logic [SW-1:0]              r_wr_slot, n_wr_slot;
    logic [SW-1:0]              r_rd_slot, n_rd_slot;
    logic [srb_pkg::CFG_W-1:0]  r_filled, n_filled;
    logic [LW-1:0]              r_len, n_len;
    logic [LW-1:0]              r_commit_len, n_commit_len;

    logic                       r_out_valid;
    srb_pkg::t_srb_code         r_out_code;
    logic                       r_out_last;
    logic [srb_pkg::CFG_W-1:0]  r_out_level;
    logic                       r_out_rd;

    logic [srb_pkg::CFG_W-1:0]  w_nslots;
    logic [srb_pkg::CFG_W-1:0]  w_nbytes;
    logic [LW-1:0]              w_len_next;
    logic [BW-1:0]              w_byte_idx;
    logic [AW-1:0]              w_wr_addr_cm;
    logic [AW-1:0]              w_rd_addr;
    logic [AW-1:0]              w_mem_waddr;
    logic [srb_pkg::DATA_W-1:0] w_mem_wdata;
    logic [srb_pkg::DATA_W-1:0] w_commit_byte;
    logic                       w_mem_we;
    logic                       w_out_load;

    // clamp the registers to the legal range
    always_comb begin
        if (i_slot_count == '0) begin
            w_nslots = srb_pkg::CFG_W'(1);
        end else if (32'(i_slot_count) > MAX_SLOTS) begin
            w_nslots = srb_pkg::CFG_W'(MAX_SLOTS);
        end else begin
            w_nslots = i_slot_count;
        end
        if (i_slot_bytes == '0) begin
            w_nbytes = srb_pkg::CFG_W'(1);
        end else if (32'(i_slot_bytes) > MAX_SLOT_BYTES) begin
            w_nbytes = srb_pkg::CFG_W'(MAX_SLOT_BYTES);
        end else begin
            w_nbytes = i_slot_bytes;
        end
    end

    // staged length saturates one past the largest slot
    assign w_len_next = (r_len <= LW'(MAX_SLOT_BYTES)) ? (r_len + LW'(1)) : r_len;

    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.ring_empty = (r_filled == '0);
    assign o_stat.ring_full  = (r_filled >= w_nslots);
    assign o_stat.len_bad    = (LCW'(w_len_next) > LCW'(w_nbytes));
    assign o_stat.nbytes     = w_nbytes;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_wr_slot    = r_wr_slot;
        n_rd_slot    = r_rd_slot;
        n_filled     = r_filled;
        n_len        = r_len;
        n_commit_len = r_commit_len;
        if (i_cmd.stage_wr) begin
            n_len = w_len_next;
        end
        if (i_cmd.fill_done) begin
            n_len        = '0;
            n_commit_len = w_len_next;
        end
        if (i_cmd.commit_go) begin
            n_wr_slot = r_head;
            n_filled  = r_filled + srb_pkg::CFG_W'(1);
            if ((r_filled + srb_pkg::CFG_W'(1)) < w_nslots) begin
                n_head = f_advance(r_head, w_nslots);
            end
        end
        if (i_cmd.rd_go) begin
            n_rd_slot = r_tail;
            n_tail    = f_advance(r_tail, w_nslots);
            n_filled  = r_filled - srb_pkg::CFG_W'(1);
            if (r_filled >= w_nslots) begin
                n_head = f_advance(r_head, w_nslots);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_filled <= '0;
            r_len    <= '0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_filled <= n_filled;
            r_len    <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_slot    <= n_wr_slot;
        r_rd_slot    <= n_rd_slot;
        r_commit_len <= n_commit_len;
        if (i_cmd.stage_wr && (r_len < LW'(MAX_SLOT_BYTES))) begin
            r_stg[r_len[BW-1:0]] <= i_data_in;
        end
    end

    // staging bytes past the message length read as padding
    assign w_byte_idx    = i_idx[BW-1:0];
    assign w_commit_byte = (LW'(w_byte_idx) < r_commit_len) ? r_stg[w_byte_idx]
                                                            : srb_pkg::PAD_BYTE;
    assign w_wr_addr_cm  = AW'(AW'(r_wr_slot) * AW'(MAX_SLOT_BYTES)) + AW'(w_byte_idx);
    assign w_rd_addr     = AW'(AW'(r_rd_slot) * AW'(MAX_SLOT_BYTES)) + AW'(w_byte_idx);

    always_comb begin
        w_mem_we    = i_cmd.mem_clr || i_cmd.commit_wr || i_cmd.rd_issue;
        w_mem_wdata = srb_pkg::PAD_BYTE;
        w_mem_waddr = w_rd_addr;
        if (i_cmd.mem_clr) begin
            w_mem_waddr = i_idx;
        end else if (i_cmd.commit_wr) begin
            w_mem_waddr = w_wr_addr_cm;
            w_mem_wdata = w_commit_byte;
        end
    end

    // a read clears the byte it returns in the same cycle
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    assign w_out_load = i_cmd.fill_done || i_cmd.rd_empty || i_cmd.rd_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_code  <= i_cmd.code;
            r_out_last  <= i_cmd.rd_issue ? i_cmd.rd_last : 1'b1;
            r_out_level <= n_filled;
            r_out_rd    <= i_cmd.rd_issue;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_code;
    assign o_data_out  = r_out_rd ? r_rdata : srb_pkg::PAD_BYTE;
    assign o_out_last  = r_out_last;
    assign o_level     = r_out_level;

endmodule

// ===== rtl/slot_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_ring_buffer: FIFO of fixed-size message slots
// Gathers byte-streamed messages into a staging slot, commits them into a ring
// of slots and streams the oldest slot back out, zero-padded, on request.
// ----------------------------------------------------------------------------
// Usage and timing: after reset the block runs a clearing pass over the slot
// memory, all MAX_SLOTS * MAX_SLOT_BYTES bytes (256 at the defaults), and stalls
// the input channel until it ends; register writes are taken throughout. A
// fill byte without the end mark is taken and gives no result. A marked
// fill byte gives one status result at once; when it commits, the staging
// slot is copied into the slot memory one byte a cycle, so the next request
// waits until the copy ends, on the single write port. A read
// of a filled ring gives slot_bytes results at one per cycle when the output
// is not stalled, each byte read from and cleared in the slot memory in the
// same cycle; a read of an empty ring gives one result. Ring state changes
// (head, tail, level) take effect when the request is accepted, and every
// result of a read carries the level left after that read.
// ----------------------------------------------------------------------------
module slot_ring_buffer #(
    parameter int MAX_SLOTS      = 16,
    parameter int MAX_SLOT_BYTES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic [srb_pkg::DATA_W-1:0] i_data_in,
    input  logic                       i_in_last,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [srb_pkg::DATA_W-1:0] o_data_out,
    output logic                       o_out_last,
    output logic [srb_pkg::CFG_W-1:0]  o_level,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [srb_pkg::APB_AW-1:0] paddr,
    input  logic [srb_pkg::APB_DW-1:0] pwdata,
    output logic [srb_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int DEPTH = MAX_SLOTS * MAX_SLOT_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [srb_pkg::CFG_W-1:0] w_slot_count;
    logic [srb_pkg::CFG_W-1:0] w_slot_bytes;
    srb_pkg::t_srb_cmd         w_cmd;
    srb_pkg::t_srb_stat        w_stat;
    logic [AW-1:0]             w_idx;

    // configuration registers
    srb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slot_count (w_slot_count),
        .o_slot_bytes (w_slot_bytes)
    );

    // sequencing: clearing pass, accept requests, drive commit and read-out sweeps
    srb_ctrl #(
        .MAX_SLOTS      (MAX_SLOTS),
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_in_last  (i_in_last),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    // storage, pointers and the result register
    srb_dpath #(
        .MAX_SLOTS      (MAX_SLOTS),
        .MAX_SLOT_BYTES (MAX_SLOT_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_idx        (w_idx),
        .i_data_in    (i_data_in),
        .i_out_stall  (i_out_stall),
        .i_slot_count (w_slot_count),
        .i_slot_bytes (w_slot_bytes),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_data_out   (o_data_out),
        .o_out_last   (o_out_last),
        .o_level      (o_level)
    );

`ifndef SYNTHESIS
    // the clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing pass");

    // an empty result is final and reports an empty ring
    a_empty_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == srb_pkg::CODE_EMPTY))
            |-> ((o_level == '0) && o_out_last))
        else $error("empty result with nonzero level or no last mark");

    // only slot bytes of a read carry data
    a_zero_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != srb_pkg::CODE_OK))
            |-> (o_data_out == srb_pkg::PAD_BYTE))
        else $error("status result carries data");

    // a read byte never overwrites a stalled result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |-> !(o_out_valid && i_out_stall))
        else $error("read byte issued over a stalled result");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the slot ring buffer
// Streams fill and read requests through the request channel, mirrors the
// ring, staging slot and registers in a class, and compares every result
// field by field against the mirror, across several register settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_SLOTS = 16;
    localparam int RING_BYTES = 16;
    localparam int SETTLE_CYC = 40;    // covers a commit copy of up to 16 bytes
    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 19;

    // One result of the block as the mirror predicts it.
    typedef struct {
        srb_pkg::t_srb_code                code;
        logic [srb_pkg::DATA_W-1:0]        data;
        logic                              last;
        logic [srb_pkg::CFG_W-1:0]         level;
    } t_ring_result;

    // Mirror of the ring: registers, slot memory, pointers, staging slot, and
    // the queue of results that the accepted requests still owe.
    class ring_mirror;
        logic [srb_pkg::CFG_W-1:0]  cfg_count;
        logic [srb_pkg::CFG_W-1:0]  cfg_bytes;
        logic [srb_pkg::DATA_W-1:0] slot_mem [RING_SLOTS*RING_BYTES];
        logic [srb_pkg::DATA_W-1:0] stage_mem [RING_BYTES];
        int unsigned                head_ptr;
        int unsigned                tail_ptr;
        int unsigned                used_slots;
        int unsigned                stage_len;
        t_ring_result               owed[$];
        int                         fail_count;

        function new();
            cfg_count  = srb_pkg::SLOT_COUNT_RST;
            cfg_bytes  = srb_pkg::SLOT_BYTES_RST;
            foreach (slot_mem[i]) slot_mem[i] = srb_pkg::PAD_BYTE;
            foreach (stage_mem[i]) stage_mem[i] = srb_pkg::PAD_BYTE;
            head_ptr   = 0;
            tail_ptr   = 0;
            used_slots = 0;
            stage_len  = 0;
            fail_count = 0;
        endfunction

        function void set_reg(logic idx, logic [srb_pkg::CFG_W-1:0] value);
            if (idx == srb_pkg::REG_SLOT_COUNT) cfg_count = value;
            else cfg_bytes = value;
        endfunction

        // Clamp the registers to the range the ring can use.
        function int unsigned live_slots();
            if (cfg_count < 1) return 1;
            if (cfg_count > RING_SLOTS) return RING_SLOTS;
            return cfg_count;
        endfunction

        function int unsigned live_bytes();
            if (cfg_bytes < 1) return 1;
            if (cfg_bytes > RING_BYTES) return RING_BYTES;
            return cfg_bytes;
        endfunction

        // Wrap to slot 0 from the last live slot or anything past it.
        function int unsigned next_slot(int unsigned p, int unsigned n);
            if (p >= n - 1) return 0;
            return (p + 1) % RING_SLOTS;
        endfunction

        function void owe(srb_pkg::t_srb_code code, logic [srb_pkg::DATA_W-1:0] data,
                          logic last);
            t_ring_result r;
            r.code  = code;
            r.data  = data;
            r.last  = last;
            r.level = srb_pkg::CFG_W'(used_slots);
            owed.push_back(r);
        endfunction

        // Advance the mirror by one accepted request and queue its results.
        function void take_request(logic op, logic [srb_pkg::DATA_W-1:0] b, logic mark);
            int unsigned        n_slots;
            int unsigned        n_bytes;
            int unsigned        base;
            srb_pkg::t_srb_code code;
            n_slots = live_slots();
            n_bytes = live_bytes();
            if (op == srb_pkg::OP_FILL) begin
                if (stage_len < RING_BYTES) stage_mem[stage_len] = b;
                if (stage_len <= RING_BYTES) stage_len++;
                if (!mark) return;
                // length check wins over the full check
                if (stage_len > n_bytes) begin
                    code = srb_pkg::CODE_BAD_LENGTH;
                end else if (used_slots >= n_slots) begin
                    code = srb_pkg::CODE_FULL;
                end else begin
                    base = head_ptr * RING_BYTES;
                    for (int i = 0; i < n_bytes; i++) slot_mem[base + i] = stage_mem[i];
                    used_slots++;
                    // head holds still on the fill that makes the ring full
                    if (used_slots < n_slots) head_ptr = next_slot(head_ptr, n_slots);
                    code = srb_pkg::CODE_OK;
                end
                foreach (stage_mem[i]) stage_mem[i] = srb_pkg::PAD_BYTE;
                stage_len = 0;
                owe(code, srb_pkg::PAD_BYTE, 1'b1);
                return;
            end
            if (used_slots == 0) begin
                owe(srb_pkg::CODE_EMPTY, srb_pkg::PAD_BYTE, 1'b1);
                return;
            end
            base = tail_ptr * RING_BYTES;
            // a read of a full ring releases the held head
            if (used_slots >= n_slots) head_ptr = next_slot(head_ptr, n_slots);
            used_slots--;
            for (int i = 0; i < n_bytes; i++) begin
                owe(srb_pkg::CODE_OK, slot_mem[base + i], (i + 1 == n_bytes));
                slot_mem[base + i] = srb_pkg::PAD_BYTE;
            end
            tail_ptr = next_slot(tail_ptr, n_slots);
        endfunction

        // Compare one accepted result against the oldest owed one.
        function void compare_result(logic [1:0] code, logic [srb_pkg::DATA_W-1:0] data,
                                     logic last, logic [srb_pkg::CFG_W-1:0] level);
            t_ring_result r;
            if (owed.size() == 0) begin
                $error("result with nothing owed: status %0d data %0h last %0b level %0d",
                       code, data, last, level);
                fail_count++;
                return;
            end
            r = owed.pop_front();
            if (code !== r.code) begin
                $error("status: expected %0d, actual %0d", r.code, code);
                fail_count++;
            end
            if (data !== r.data) begin
                $error("data_out: expected %0h, actual %0h", r.data, data);
                fail_count++;
            end
            if (last !== r.last) begin
                $error("out_last: expected %0b, actual %0b", r.last, last);
                fail_count++;
            end
            if (level !== r.level) begin
                $error("level: expected %0d, actual %0d", r.level, level);
                fail_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals, inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic                       i_op        = srb_pkg::OP_FILL;
    logic [srb_pkg::DATA_W-1:0] i_data_in   = '0;
    logic                       i_in_last   = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [1:0]                 o_status;
    logic [srb_pkg::DATA_W-1:0] o_data_out;
    logic                       o_out_last;
    logic [srb_pkg::CFG_W-1:0]  o_level;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [srb_pkg::APB_AW-1:0] paddr       = '0;
    logic [srb_pkg::APB_DW-1:0] pwdata      = '0;
    logic [srb_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    ring_mirror mirror;
    int         burst_left = 0;

    slot_ring_buffer #(
        .MAX_SLOTS      (RING_SLOTS),
        .MAX_SLOT_BYTES (RING_BYTES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_data_in   (i_data_in),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_data_out  (o_data_out),
        .o_out_last  (o_out_last),
        .o_level     (o_level),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: stall on a pattern that switches between no stall, random
    // single stalls and runs of stall, so gaps can land on any read byte.
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 30;
    int run_left   = 0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
            0: begin
                i_out_stall = 1'b0;
            end
            1: begin
                i_out_stall = ($urandom_range(0, 2) == 0);
            end
            default: begin
                if (run_left == 0) begin
                    i_out_stall = ~i_out_stall;
                    run_left    = $urandom_range(1, 6);
                end
                run_left--;
            end
        endcase
    end

    // Check every result taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.compare_result(o_status, o_data_out, o_out_last, o_level);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Send one request in bursts: open a random gap before each new burst,
    // hold the payload until it is taken, and note it in the mirror.
    // Enter and leave at a falling edge.
    task automatic send_req(input logic op, input logic [srb_pkg::DATA_W-1:0] b,
                            input logic mark);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_op       = op;
        i_data_in  = b;
        i_in_last  = mark;
        do @(posedge i_clk); while (o_in_stall);
        mirror.take_request(op, b, mark);
        @(negedge i_clk);
    endtask

    // Stream a message of len bytes; mark the final byte if asked.
    task automatic send_msg(input int len, input logic mark);
        for (int i = 0; i < len; i++)
            send_req(srb_pkg::OP_FILL, srb_pkg::DATA_W'($urandom), mark && (i == len - 1));
    endtask

    task automatic send_read();
        send_req(srb_pkg::OP_READ, srb_pkg::DATA_W'($urandom), 1'($urandom));
    endtask

    // Drop valid, wait for every owed result, then let the commit copy finish.
    task automatic drain();
        i_in_valid = 1'b0;
        burst_left = 0;
        while (mirror.owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Register write: setup cycle then access cycle, held until pready.
    task automatic reg_write(input logic idx, input logic [srb_pkg::CFG_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = srb_pkg::APB_AW'({idx, 2'b00});
        pwdata  = srb_pkg::APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_ring(input logic [srb_pkg::CFG_W-1:0] count,
                            input logic [srb_pkg::CFG_W-1:0] bytes);
        reg_write(srb_pkg::REG_SLOT_COUNT, count);
        reg_write(srb_pkg::REG_SLOT_BYTES, bytes);
    endtask

    // Random phase: mostly well-formed messages and reads, plus overlong
    // messages and messages broken by a read in the middle.
    task automatic run_phase(input int reqs, input bit hold_mid);
        int done;
        int pick;
        int len;
        int n_bytes;
        done    = 0;
        n_bytes = mirror.live_bytes();
        while (done < reqs) begin
            if (hold_mid && done >= reqs / 2) begin
                // pause until the block owes nothing
                drain();
                hold_mid = 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                len = ($urandom_range(0, 3) == 0) ? n_bytes : $urandom_range(1, n_bytes);
                send_msg(len, 1'b1);
                done += len;
            end else if (pick < 85) begin
                send_read();
                done++;
            end else if (pick < 93) begin
                len = $urandom_range(n_bytes + 1, RING_BYTES + 4);
                send_msg(len, 1'b1);
                done += len;
            end else begin
                len = $urandom_range(1, n_bytes);
                send_msg(len - 1, 1'b0);
                send_read();
                send_msg(1, 1'b1);
                done += len + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    logic [srb_pkg::CFG_W-1:0] count_set [PHASES] = '{16, 1, 31, 0, 3, 16, 8, 5, 2, 12};
    logic [srb_pkg::CFG_W-1:0] bytes_set [PHASES] = '{16, 1, 0, 31, 16, 7, 3, 12, 16, 5};

    initial begin
        mirror = new();
        // hold reset from time zero, release at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: two slots of four bytes reach every status quickly.
        set_ring(5'd2, 5'd4);
        send_read();                                // read of an empty ring
        send_req(srb_pkg::OP_FILL, 8'hFF, 1'b1);    // one-byte message
        send_req(srb_pkg::OP_FILL, 8'h00, 1'b0);    // full-length message fills the ring
        send_req(srb_pkg::OP_FILL, 8'hA5, 1'b0);
        send_req(srb_pkg::OP_FILL, 8'h5A, 1'b0);
        send_req(srb_pkg::OP_FILL, 8'hFF, 1'b1);
        send_req(srb_pkg::OP_FILL, 8'h11, 1'b1);    // ring full
        send_msg(5, 1'b1);                          // too long and full: length wins
        send_req(srb_pkg::OP_FILL, 8'h3C, 1'b0);    // read in the middle of a message
        send_req(srb_pkg::OP_READ, 8'hFF, 1'b1);
        send_req(srb_pkg::OP_FILL, 8'hC3, 1'b1);
        send_req(srb_pkg::OP_READ, 8'h00, 1'b0);
        send_read();
        send_read();                                // empty again
        drain();

        // Random phases over several register settings, extremes included.
        for (int p = 0; p < PHASES; p++) begin
            if (p >= 5 && $urandom_range(0, 1) == 0)
                set_ring(srb_pkg::CFG_W'($urandom_range(1, 16)),
                         srb_pkg::CFG_W'($urandom_range(1, 16)));
            else
                set_ring(count_set[p], bytes_set[p]);
            run_phase(PHASE_REQS, p == 3);
            drain();
        end

        if (mirror.fail_count == 0 && mirror.owed.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/srb_pkg.sv
rtl/srb_regs.sv
rtl/srb_ctrl.sv
rtl/srb_dpath.sv
rtl/slot_ring_buffer.sv
tb/sv/testbench.sv
